>>> hw/rtl/frame_rate_meter_top_assert.svh
// Assertion macros for the frame rate meter.
// Used by frame_rate_meter_top; expects clk and rst_n in scope.
`ifndef FRAME_RATE_METER_TOP_ASSERT_SVH
`define FRAME_RATE_METER_TOP_ASSERT_SVH

// same-cycle implication
`define FRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/frm_pkg.sv
// Shared constants and types for the frame rate meter.
// No dependencies.
package frm_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int DELTA_W          = 16;
  localparam int RATE_W           = 14;
  localparam int RATING_W         = 2;
  localparam int RATE_SCALE       = 1000;
  localparam int RATE_MAX         = 16383;
  localparam int RESET_BAD        = 30;
  localparam int RESET_WARN       = 55;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_IDX = 2'd1;

  typedef enum logic [RATING_W-1:0] {
    RATING_GOOD = 2'd0,
    RATING_WARN = 2'd1,
    RATING_BAD  = 2'd2
  } rating_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frm_div_st_t;

endpackage

>>> hw/rtl/frm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on frm_pkg for the status struct.
module frm_div #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [DEN_W-1:0]   divisor,
  output logic [NUM_W-1:0]   quotient,
  output frm_pkg::frm_div_st_t status
);
  import frm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> hw/rtl/frame_rate_meter_top.sv
// Each delta passes S_READ, S_SETUP, S_DIV and S_DONE before the next is taken;
// S_DIV waits on the bit-serial divider (NUM_W = bits of 1000 * WINDOW_DEPTH,
// 14 at default depth) and is skipped when the window sum is not positive.
// Synchronous active-low reset clears fill count, slot and sum and presets the
// thresholds; the ring is not cleared, the fill count covers unwritten slots.
module frame_rate_meter_top #(
  parameter int WINDOW_DEPTH = frm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] frame_delta_ms
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [13:0] frames_per_second, [29:14] latest_delta_ms, [31:30] rate_rating
  output logic [31:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frm_pkg::*;
  `include "frame_rate_meter_top_assert.svh"

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = DELTA_W + $clog2(WINDOW_DEPTH);
  localparam int NUM_W  = $clog2(RATE_SCALE * WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SETUP, S_DIV, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [RATE_W-1:0]        bad_r, bad_nxt;
  logic [RATE_W-1:0]        warn_r, warn_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic [RATE_W-1:0]        rate_r, rate_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]        out_fps_r, out_fps_nxt;
  logic [DELTA_W-1:0]       out_delta_r, out_delta_nxt;
  rating_t                  out_rating_r, out_rating_nxt;

  logic signed [DELTA_W-1:0] ring_mem [WINDOW_DEPTH];
  logic signed [DELTA_W-1:0] ring_rd_r;

  logic                     in_xfer, full, div_start, sum_pos;
  logic [NUM_W-1:0]         div_num, div_quo;
  logic [SUM_W-2:0]         div_den;
  frm_div_st_t              div_st;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign full      = (cnt_r == CNT_W'(WINDOW_DEPTH));
  assign sum_pos   = !sum_r[SUM_W-1] && (sum_r != '0);
  assign div_num   = NUM_W'(32'(cnt_r) * RATE_SCALE);
  assign div_den   = sum_r[SUM_W-2:0];

  frm_div #(
    .NUM_W(NUM_W),
    .DEN_W(SUM_W - 1)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (div_den),
    .quotient(div_quo),
    .status  (div_st)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring_rd_r <= ring_mem[slot_r];
    end
    if (state_r == S_READ) begin
      ring_mem[slot_r] <= delta_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    bad_nxt        = bad_r;
    warn_nxt       = warn_r;
    delta_nxt      = delta_r;
    rate_nxt       = rate_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_fps_nxt    = out_fps_r;
    out_delta_nxt  = out_delta_r;
    out_rating_nxt = out_rating_r;
    div_start      = 1'b0;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BAD_IDX) begin
        bad_nxt = RATE_W'(cfg_data);
      end else if (cfg_index == CFG_WARN_IDX) begin
        warn_nxt = RATE_W'(cfg_data);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          delta_nxt = in_tdata;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        sum_nxt = sum_r + SUM_W'(delta_r) - (full ? SUM_W'(ring_rd_r) : SUM_W'(0));
        if (!full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (sum_pos) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          rate_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          rate_nxt  = (32'(div_quo) > RATE_MAX) ? RATE_W'(RATE_MAX) : RATE_W'(div_quo);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_fps_nxt   = rate_r;
          out_delta_nxt = delta_r;
          if (rate_r < bad_r) begin
            out_rating_nxt = RATING_BAD;
          end else if (rate_r < warn_r) begin
            out_rating_nxt = RATING_WARN;
          end else begin
            out_rating_nxt = RATING_GOOD;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      bad_r       <= RATE_W'(RESET_BAD);
      warn_r      <= RATE_W'(RESET_WARN);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      bad_r       <= bad_nxt;
      warn_r      <= warn_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r      <= delta_nxt;
    rate_r       <= rate_nxt;
    out_fps_r    <= out_fps_nxt;
    out_delta_r  <= out_delta_nxt;
    out_rating_r <= out_rating_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rating_r, out_delta_r, out_fps_r};

  `FRM_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(WINDOW_DEPTH), "fill count beyond depth")
  `FRM_ASSERT_NEXT(a_xfer_read, in_xfer, state_r == S_READ, "transfer did not start update")
  `FRM_ASSERT_NOW(a_div_state, div_st.done, state_r == S_DIV, "divider done outside divide")
  `FRM_ASSERT_NOW(a_div_busy, state_r == S_DIV, div_st.busy || div_st.done, "divider idle")
  `FRM_ASSERT_NEXT(a_out_hold, state_r == S_DONE && out_valid_r && !out_tready,
                   state_r == S_DONE, "pending result overwritten")

endmodule

>>> sim/frame_rate_meter_top_tb.sv
// Self-checking testbench for frame_rate_meter_top: predicts the moving-average
// rate, latest delta and rating per frame and compares every output transfer.
// Depends on frm_pkg and the frame_rate_meter_top RTL.
module frame_rate_meter_top_tb;
  import frm_pkg::*;

  localparam int DEPTH        = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [RATE_W-1:0]  fps;
    logic [DELTA_W-1:0] delta;
    rating_t            rating;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  reading_t                  pending_readings[$];
  logic signed [DELTA_W-1:0] hist [DEPTH];
  int                        hist_slot;
  int                        hist_fill;
  int                        hist_sum;
  logic [RATE_W-1:0]         bad_thr;
  logic [RATE_W-1:0]         warn_thr;
  int                        err_cnt   = 0;
  int                        cycle_cnt = 0;
  int                        hold_left = 0;

  frame_rate_meter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void predict_reading(input logic signed [DELTA_W-1:0] d);
    reading_t r;
    longint   rate;
    if (hist_fill >= DEPTH) hist_sum -= int'(hist[hist_slot]);
    hist[hist_slot] = d;
    hist_sum += int'(d);
    hist_slot = (hist_slot + 1) % DEPTH;
    if (hist_fill < DEPTH) hist_fill++;
    rate = 0;
    if (hist_sum > 0) begin
      rate = longint'(RATE_SCALE * hist_fill) / longint'(hist_sum);
      if (rate > RATE_MAX) rate = RATE_MAX;
    end
    r.fps   = rate[RATE_W-1:0];
    r.delta = d;
    if (rate < longint'(bad_thr)) r.rating = RATING_BAD;
    else if (rate < longint'(warn_thr)) r.rating = RATING_WARN;
    else r.rating = RATING_GOOD;
    pending_readings.push_back(r);
  endfunction

  // delta that brings the window sum to the target once stored
  function automatic logic [15:0] delta_for_sum(input int target);
    int rest;
    int d;
    rest = hist_sum - ((hist_fill >= DEPTH) ? int'(hist[hist_slot]) : 0);
    d = target - rest;
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    return d[15:0];
  endfunction

  function automatic logic [15:0] pick_delta();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 3));
      2: v = 16'd0 - 16'($urandom_range(1, 60));
      3: begin
        case ($urandom_range(0, 3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      default: v = 16'($urandom_range(5, 120));
    endcase
    return v;
  endfunction

  function automatic logic [RATE_W-1:0] pick_threshold();
    logic [RATE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = RATE_W'($urandom_range(0, 16383));
      default: v = RATE_W'($urandom_range(0, 150));
    endcase
    return v;
  endfunction

  task automatic pause_sender(input int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_delta(input logic [15:0] d);
    in_tdata  = d;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_reading(d);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain_readings();
    while (pending_readings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    drain_readings();
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(val);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BAD_IDX) bad_thr = val;
    else warn_thr = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // receiver: ready pattern changes in spans, long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    out_tready = 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ((tick % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : reading_check
    reading_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transfer, expected none, got %h", $time, out_tdata);
      end else begin
        exp_r = pending_readings.pop_front();
        check_field("frames_per_second", 16'(exp_r.fps), 16'(out_tdata[13:0]));
        check_field("latest_delta_ms", exp_r.delta, out_tdata[29:14]);
        check_field("rate_rating", 16'(exp_r.rating), 16'(out_tdata[31:30]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_edge_deltas();
    int targets [7];
    targets = '{1, 533, 534, 290, 291, 0, -5};
    send_delta(16'h0000);
    send_delta(16'hFFFF);
    send_delta(16'h8000);
    send_delta(16'h7FFF);
    send_delta(16'h0001);
    repeat (11) send_delta(16'h0000);
    // window now full: hit top rate, both threshold edges, zero and negative sum
    foreach (targets[i]) send_delta(delta_for_sum(targets[i]));
  endtask

  task automatic test_thresholds();
    logic [RATE_W-1:0] bad_set [5];
    logic [RATE_W-1:0] warn_set [5];
    bad_set  = '{14'd0, 14'd0,     14'd16383, 14'd100, 14'd16383};
    warn_set = '{14'd0, 14'd16383, 14'd16383, 14'd50,  14'd0};
    foreach (bad_set[i]) begin
      write_reg(CFG_BAD_IDX, bad_set[i]);
      write_reg(CFG_WARN_IDX, warn_set[i]);
      send_delta(delta_for_sum(0));
      repeat (5) send_delta(pick_delta());
    end
  endtask

  task automatic test_backpressure();
    drain_readings();
    hold_left = 300;
    repeat (24) send_delta(16'($urandom_range(5, 60)));
    drain_readings();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      if (sent > 0 && $urandom_range(0, 99) < 8) begin
        write_reg(CFG_BAD_IDX, pick_threshold());
        write_reg(CFG_WARN_IDX, pick_threshold());
      end
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        send_delta(pick_delta());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BAD_IDX;
    cfg_data  = '0;
    foreach (hist[i]) hist[i] = '0;
    hist_slot = 0;
    hist_fill = 0;
    hist_sum  = 0;
    bad_thr   = RATE_W'(RESET_BAD);
    warn_thr  = RATE_W'(RESET_WARN);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_deltas();
    test_thresholds();
    test_backpressure();
    test_random_traffic(475);

    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
